FILE: rtl/pett_pkg.sv
package pett_pkg;

   // Table geometry
   localparam int NUM_SOURCES      = 2;
   localparam int SLOTS_PER_SOURCE = 2;

   localparam int SRC_W  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
   localparam int SLOT_W = (SLOTS_PER_SOURCE > 1) ? $clog2(SLOTS_PER_SOURCE) : 1;
   localparam int SPAN_W = $clog2(SLOTS_PER_SOURCE + 1);
   localparam int MEM_AW = SRC_W + SLOT_W;
   localparam int MEM_DEPTH = 1 << MEM_AW;

   // Field widths
   localparam int TIME_W       = 16;
   localparam int TAG_W        = 8;
   localparam int FIELD_SLOT_W = 4;
   localparam int CMP_W        = FIELD_SLOT_W + 1;

   // Status codes
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef enum logic [1:0] {
      FUNC_TICK   = 2'd0,
      FUNC_ADD    = 2'd1,
      FUNC_REMOVE = 2'd2,
      FUNC_RSVD   = 2'd3
   } func_type;

   typedef struct packed {
      func_type                  func;
      logic                      timer_sel;
      logic [FIELD_SLOT_W-1:0]   slot;
      logic [TIME_W-1:0]         period;
      logic [TAG_W-1:0]          handler_tag;
   } req_type;

   typedef struct packed {
      logic                      status;
      logic [FIELD_SLOT_W-1:0]   slot_out;
      logic                      fired;
      logic [TAG_W-1:0]          fired_tag;
      logic                      last;
   } rsp_type;

   // One slot entry as kept in the slot memory
   typedef struct packed {
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] start;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   // Remainder unit status toward the sequencer
   typedef struct packed {
      logic done;
      logic zero;
   } rem_stat_type;

endpackage

FILE: rtl/pett_if.sv
// Request channel
interface pett_req_if;
   logic              valid;
   logic              ready;
   pett_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// Response channel
interface pett_rsp_if;
   logic              valid;
   logic              ready;
   pett_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/pett_rem_unit.sv
// Bit-serial restoring remainder: one quotient bit per cycle.
module pett_rem_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pett_pkg::TIME_W-1:0]   dividend,
   input  logic [pett_pkg::TIME_W-1:0]   divisor,
   output pett_pkg::rem_stat_type        stat
);

   localparam int W     = pett_pkg::TIME_W;
   localparam int CNT_W = $clog2(W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]     dvd_ff, dvd_in;
   logic [W-1:0]     dvs_ff, dvs_in;
   logic [W-1:0]     rem_ff, rem_in;

   logic [W:0]       trial;
   logic             trial_ge;

   // One restoring step
   assign trial    = {rem_ff, dvd_ff[W-1]};
   assign trial_ge = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(W - 1);
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = trial_ge ? W'(trial - {1'b0, dvs_ff}) : trial[W-1:0];
         dvd_in = {dvd_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign stat.done = done_ff;
   assign stat.zero = (rem_ff == '0);

endmodule

FILE: rtl/periodic_event_timer_table_core.sv
// Periodic event timer table. Each tick source owns a small table of periodic
// events; add, remove and tick requests arrive one at a time on req_ch and every
// request yields one or more responses on rsp_ch, the final one flagged by last.
// Add and remove go through accept, decode and response load. A tick goes
// through accept and decode, skips each free slot in the used span and, for
// each enabled slot, does a memory read, a remainder start and the bit-serial
// remainder of elapsed time by period, then loads each firing. A stalled
// rsp_ch adds its wait to the response load, and to a firing that finds the
// output register still full. The period, start time and tag of each slot sit
// in a one-port-write, one-port-read slot memory; enable bits and time per
// source are flip-flops cleared by reset and span is reset to one, so no
// clearing pass is needed. A new request can be taken while the last response
// waits on rsp_ch.
module periodic_event_timer_table_core (
   input  logic       clock,
   input  logic       reset,
   pett_req_if.sink   req_ch,
   pett_rsp_if.source rsp_ch
);

   localparam int NSRC   = pett_pkg::NUM_SOURCES;
   localparam int NSLOT  = pett_pkg::SLOTS_PER_SOURCE;
   localparam int SRC_W  = pett_pkg::SRC_W;
   localparam int SLOT_W = pett_pkg::SLOT_W;
   localparam int SPAN_W = pett_pkg::SPAN_W;
   localparam int TIME_W = pett_pkg::TIME_W;
   localparam int TAG_W  = pett_pkg::TAG_W;
   localparam int FSW    = pett_pkg::FIELD_SLOT_W;
   localparam int CMP_W  = pett_pkg::CMP_W;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DECODE = 7'b0000010,
      ST_SCAN   = 7'b0000100,
      ST_READ   = 7'b0001000,
      ST_DIV    = 7'b0010000,
      ST_HIT    = 7'b0100000,
      ST_FINAL  = 7'b1000000
   } state_type;

   // Sequencer and request state
   state_type             state_ff, state_in;
   pett_pkg::req_type     req_ff, req_in;
   logic [SPAN_W-1:0]     idx_ff, idx_in;
   logic                  pend_v_ff, pend_v_in;
   logic [FSW-1:0]        pend_slot_ff, pend_slot_in;
   logic [TAG_W-1:0]      pend_tag_ff, pend_tag_in;
   pett_pkg::rsp_type     res_ff, res_in;

   // Per-source state
   logic                  en_ff   [NSRC][NSLOT];
   logic                  en_in   [NSRC][NSLOT];
   logic [TIME_W-1:0]     time_ff [NSRC];
   logic [TIME_W-1:0]     time_in [NSRC];
   logic [SPAN_W-1:0]     span_ff [NSRC];
   logic [SPAN_W-1:0]     span_in [NSRC];

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   pett_pkg::rsp_type     rsp_data_ff, rsp_data_in;
   logic                  out_free;
   logic                  out_load;
   pett_pkg::rsp_type     out_data;

   // Slot memory
   pett_pkg::entry_type   mem [pett_pkg::MEM_DEPTH];
   pett_pkg::entry_type   rd_data_ff;
   logic                  mem_we;
   logic [pett_pkg::MEM_AW-1:0] mem_waddr;
   logic [pett_pkg::MEM_AW-1:0] mem_raddr;
   pett_pkg::entry_type   mem_wdata;
   logic                  rd_en;

   // Remainder unit
   logic                  rem_start;
   logic [TIME_W-1:0]     rem_dividend;
   logic [TIME_W-1:0]     rem_divisor;
   pett_pkg::rem_stat_type rem_stat;

   // Decode helpers
   logic [SRC_W-1:0]      src_idx;
   logic                  src_ok;
   logic [SPAN_W-1:0]     cur_span;
   logic [TIME_W-1:0]     cur_time;
   logic [SPAN_W-1:0]     add_pick;
   logic                  add_full;
   logic                  rm_bad;
   logic                  rm_top;

   assign src_idx  = SRC_W'(req_ff.timer_sel);
   assign src_ok   = int'(req_ff.timer_sel) < NSRC;
   assign cur_span = span_ff[src_idx];
   assign cur_time = time_ff[src_idx];

   // Lowest free slot below the span, else the span itself
   always_comb begin
      add_pick = cur_span;
      for (int i = NSLOT - 1; i >= 0; i--) begin
         if (SPAN_W'(i) < cur_span && !en_ff[src_idx][i])
            add_pick = SPAN_W'(i);
      end
   end

   assign add_full = add_pick >= SPAN_W'(NSLOT);
   assign rm_bad   = !src_ok || CMP_W'(req_ff.slot) >= CMP_W'(cur_span)
                     || CMP_W'(req_ff.slot) >= CMP_W'(NSLOT);
   assign rm_top   = (CMP_W'(req_ff.slot) + CMP_W'(1)) == CMP_W'(cur_span);

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign mem_raddr    = {src_idx, idx_ff[SLOT_W-1:0]};
   assign rem_dividend = cur_time - rd_data_ff.start;
   assign rem_divisor  = (rd_data_ff.period == '0) ? TIME_W'(1) : rd_data_ff.period;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      pend_v_in    = pend_v_ff;
      pend_slot_in = pend_slot_ff;
      pend_tag_in  = pend_tag_ff;
      res_in       = res_ff;
      en_in        = en_ff;
      time_in      = time_ff;
      span_in      = span_ff;
      out_load     = 1'b0;
      out_data     = '0;
      mem_we       = 1'b0;
      mem_waddr    = {src_idx, add_pick[SLOT_W-1:0]};
      mem_wdata.period = (req_ff.period == '0) ? TIME_W'(1) : req_ff.period;
      mem_wdata.start  = cur_time;
      mem_wdata.tag    = req_ff.handler_tag;
      rd_en        = 1'b0;
      rem_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               req_in   = req_ch.data;
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            res_in      = '0;
            res_in.last = 1'b1;
            state_in    = ST_FINAL;
            case (req_ff.func)
               pett_pkg::FUNC_TICK: begin
                  if (src_ok) begin
                     time_in[src_idx] = cur_time + TIME_W'(1);
                     idx_in    = '0;
                     pend_v_in = 1'b0;
                     state_in  = ST_SCAN;
                  end
               end
               pett_pkg::FUNC_ADD: begin
                  if (!src_ok || req_ff.handler_tag == '0 || add_full) begin
                     res_in.status = pett_pkg::STATUS_REJECT;
                  end else begin
                     en_in[src_idx][add_pick[SLOT_W-1:0]] = 1'b1;
                     if (add_pick == cur_span)
                        span_in[src_idx] = add_pick + SPAN_W'(1);
                     mem_we          = 1'b1;
                     res_in.status   = pett_pkg::STATUS_OK;
                     res_in.slot_out = FSW'(add_pick);
                  end
               end
               pett_pkg::FUNC_REMOVE: begin
                  res_in.slot_out = req_ff.slot;
                  if (rm_bad) begin
                     res_in.status = pett_pkg::STATUS_REJECT;
                  end else begin
                     en_in[src_idx][req_ff.slot[SLOT_W-1:0]] = 1'b0;
                     if (rm_top)
                        span_in[src_idx] = cur_span - SPAN_W'(1);
                     res_in.status = pett_pkg::STATUS_OK;
                  end
               end
               default: begin
                  res_in.status = pett_pkg::STATUS_REJECT;
               end
            endcase
         end

         // Walk the span; the held firing becomes the final response
         ST_SCAN: begin
            if (idx_ff >= SPAN_W'(NSLOT) || idx_ff >= cur_span) begin
               res_in      = '0;
               res_in.last = 1'b1;
               if (pend_v_ff) begin
                  res_in.slot_out  = pend_slot_ff;
                  res_in.fired     = 1'b1;
                  res_in.fired_tag = pend_tag_ff;
               end
               state_in = ST_FINAL;
            end else if (!en_ff[src_idx][idx_ff[SLOT_W-1:0]]) begin
               idx_in = idx_ff + SPAN_W'(1);
            end else begin
               rd_en    = 1'b1;
               state_in = ST_READ;
            end
         end

         ST_READ: begin
            rem_start = 1'b1;
            state_in  = ST_DIV;
         end

         ST_DIV: begin
            if (rem_stat.done) begin
               if (rem_stat.zero) begin
                  state_in = ST_HIT;
               end else begin
                  idx_in   = idx_ff + SPAN_W'(1);
                  state_in = ST_SCAN;
               end
            end
         end

         // Release the previous firing, hold this one
         ST_HIT: begin
            if (!pend_v_ff || out_free) begin
               if (pend_v_ff) begin
                  out_load           = 1'b1;
                  out_data.status    = pett_pkg::STATUS_OK;
                  out_data.slot_out  = pend_slot_ff;
                  out_data.fired     = 1'b1;
                  out_data.fired_tag = pend_tag_ff;
                  out_data.last      = 1'b0;
               end
               pend_v_in    = 1'b1;
               pend_slot_in = FSW'(idx_ff);
               pend_tag_in  = rd_data_ff.tag;
               idx_in       = idx_ff + SPAN_W'(1);
               state_in     = ST_SCAN;
            end
         end

         ST_FINAL: begin
            if (out_free) begin
               out_load = 1'b1;
               out_data = res_ff;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ch.ready = (state_ff == ST_IDLE);

   // Output register
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ch.ready);
   assign rsp_data_in  = out_load ? out_data : rsp_data_ff;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < NSRC; s++) begin
            time_ff[s] <= '0;
            span_ff[s] <= SPAN_W'(1);
            for (int i = 0; i < NSLOT; i++)
               en_ff[s][i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
         time_ff      <= time_in;
         span_ff      <= span_in;
         en_ff        <= en_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      idx_ff       <= idx_in;
      pend_slot_ff <= pend_slot_in;
      pend_tag_ff  <= pend_tag_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Slot memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we)
         mem[mem_waddr] <= mem_wdata;
      if (rd_en)
         rd_data_ff <= mem[mem_raddr];
   end

   pett_rem_unit u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (rem_dividend),
      .divisor  (rem_divisor),
      .stat     (rem_stat)
   );

endmodule

FILE: rtl/pett_checker.sv
// Port-level checks for the timer table
module pett_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input pett_pkg::rsp_type rsp_data
);

   logic       req_fire;
   logic       last_fire;
   logic [1:0] open_ff, open_in;

   assign req_fire  = req_valid && req_ready;
   assign last_fire = rsp_valid && rsp_ready && rsp_data.last;

   // Requests whose final response is not yet taken
   always_comb begin
      open_in = open_ff;
      if (req_fire && !last_fire)
         open_in = open_ff + 2'd1;
      else if (!req_fire && last_fire)
         open_in = open_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 2'd0)
      else $error("response without an open request");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> open_ff < 2'd2)
      else $error("request taken while another is still in work");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("ready right after taking a request");

   a_fired_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fired |->
         rsp_data.status == pett_pkg::STATUS_OK && rsp_data.fired_tag != '0)
      else $error("firing response with bad status or empty tag");

endmodule

bind periodic_event_timer_table_core pett_checker u_pett_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data)
);

FILE: tb/periodic_event_timer_table_core_test.sv
`timescale 1ns / 100ps

module periodic_event_timer_table_core_test;

   localparam int NSRC          = pett_pkg::NUM_SOURCES;
   localparam int NSLOT         = pett_pkg::SLOTS_PER_SOURCE;
   localparam int FSW           = pett_pkg::FIELD_SLOT_W;
   localparam int RANDOM_ITEMS  = 425;
   localparam int LONG_HOLD     = 300;
   localparam int DRAIN_CYCLES  = 60;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int REPORT_LIMIT  = 10;
   localparam int DIRECTED_ROWS = 25;
   localparam bit TYPED         = 1'b1;
   localparam bit PREDICT       = 1'b0;

   // One directed step: request, whether the response is written out, that response
   typedef struct packed {
      pett_pkg::req_type req;
      logic              typed;
      pett_pkg::rsp_type rsp;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset;

   pett_req_if req_bus ();
   pett_rsp_if rsp_bus ();

   periodic_event_timer_table_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Directed steps: error codes, field extremes, span growth and shrink, coincident firing
   plan_row_type plan [DIRECTED_ROWS] = '{
      // tick right after reset: nothing enabled
      {{pett_pkg::FUNC_TICK,   1'b0, 4'd0, 16'd0,     8'd0 }, TYPED,
       {pett_pkg::STATUS_OK,     4'd0, 1'b0, 8'd0, 1'b1}},
      // unknown operation, all other fields at their top
      {{pett_pkg::FUNC_RSVD,   1'b1, 4'hF, 16'hFFFF,  8'hFF}, TYPED,
       {pett_pkg::STATUS_REJECT, 4'd0, 1'b0, 8'd0, 1'b1}},
      // add without a handler
      {{pett_pkg::FUNC_ADD,    1'b0, 4'd0, 16'd3,     8'd0 }, TYPED,
       {pett_pkg::STATUS_REJECT, 4'd0, 1'b0, 8'd0, 1'b1}},
      // remove beyond the span
      {{pett_pkg::FUNC_REMOVE, 1'b0, 4'hF, 16'd0,     8'd0 }, TYPED,
       {pett_pkg::STATUS_REJECT, 4'hF, 1'b0, 8'd0, 1'b1}},
      // zero period stored as one, top tag
      {{pett_pkg::FUNC_ADD,    1'b0, 4'hF, 16'd0,     8'hFF}, TYPED,
       {pett_pkg::STATUS_OK,     4'd0, 1'b0, 8'd0, 1'b1}},
      {{pett_pkg::FUNC_ADD,    1'b0, 4'd0, 16'hFFFF,  8'h01}, TYPED,
       {pett_pkg::STATUS_OK,     4'd1, 1'b0, 8'd0, 1'b1}},
      // table full
      {{pett_pkg::FUNC_ADD,    1'b0, 4'd0, 16'd5,     8'h55}, TYPED,
       {pett_pkg::STATUS_REJECT, 4'd0, 1'b0, 8'd0, 1'b1}},
      {{pett_pkg::FUNC_TICK,   1'b0, 4'd7, 16'h1234,  8'h33}, PREDICT, 15'd0},
      {{pett_pkg::FUNC_TICK,   1'b0, 4'd0, 16'd0,     8'd0 }, PREDICT, 15'd0},
      // top slot removed, span shrinks; then span emptied
      {{pett_pkg::FUNC_REMOVE, 1'b0, 4'd1, 16'd0,     8'd0 }, TYPED,
       {pett_pkg::STATUS_OK,     4'd1, 1'b0, 8'd0, 1'b1}},
      {{pett_pkg::FUNC_REMOVE, 1'b0, 4'd0, 16'd0,     8'd0 }, TYPED,
       {pett_pkg::STATUS_OK,     4'd0, 1'b0, 8'd0, 1'b1}},
      {{pett_pkg::FUNC_REMOVE, 1'b0, 4'd0, 16'd0,     8'd0 }, TYPED,
       {pett_pkg::STATUS_REJECT, 4'd0, 1'b0, 8'd0, 1'b1}},
      {{pett_pkg::FUNC_TICK,   1'b0, 4'd0, 16'd0,     8'd0 }, TYPED,
       {pett_pkg::STATUS_OK,     4'd0, 1'b0, 8'd0, 1'b1}},
      // second source: periods 2 and 3 coincide on the sixth tick
      {{pett_pkg::FUNC_ADD,    1'b1, 4'd0, 16'd2,     8'hAA}, TYPED,
       {pett_pkg::STATUS_OK,     4'd0, 1'b0, 8'd0, 1'b1}},
      {{pett_pkg::FUNC_ADD,    1'b1, 4'd0, 16'd3,     8'h5A}, TYPED,
       {pett_pkg::STATUS_OK,     4'd1, 1'b0, 8'd0, 1'b1}},
      {{pett_pkg::FUNC_TICK,   1'b1, 4'd0, 16'd0,     8'd0 }, PREDICT, 15'd0},
      {{pett_pkg::FUNC_TICK,   1'b1, 4'd0, 16'd0,     8'd0 }, PREDICT, 15'd0},
      {{pett_pkg::FUNC_TICK,   1'b1, 4'd0, 16'd0,     8'd0 }, PREDICT, 15'd0},
      {{pett_pkg::FUNC_TICK,   1'b1, 4'd0, 16'd0,     8'd0 }, PREDICT, 15'd0},
      {{pett_pkg::FUNC_TICK,   1'b1, 4'd0, 16'd0,     8'd0 }, PREDICT, 15'd0},
      {{pett_pkg::FUNC_TICK,   1'b1, 4'd0, 16'd0,     8'd0 }, PREDICT, 15'd0},
      // remove below the top keeps the span; removing a free slot is accepted
      {{pett_pkg::FUNC_REMOVE, 1'b1, 4'd0, 16'd0,     8'd0 }, TYPED,
       {pett_pkg::STATUS_OK,     4'd0, 1'b0, 8'd0, 1'b1}},
      {{pett_pkg::FUNC_REMOVE, 1'b1, 4'd0, 16'd0,     8'd0 }, TYPED,
       {pett_pkg::STATUS_OK,     4'd0, 1'b0, 8'd0, 1'b1}},
      // the freed hole is reused
      {{pett_pkg::FUNC_ADD,    1'b1, 4'd9, 16'd4,     8'h10}, TYPED,
       {pett_pkg::STATUS_OK,     4'd0, 1'b0, 8'd0, 1'b1}},
      {{pett_pkg::FUNC_REMOVE, 1'b1, 4'd2, 16'd0,     8'd0 }, TYPED,
       {pett_pkg::STATUS_REJECT, 4'd2, 1'b0, 8'd0, 1'b1}}
   };

   // Mirror of the event tables
   logic        ev_on     [NSRC][NSLOT] = '{default: '{default: 1'b0}};
   logic [15:0] ev_period [NSRC][NSLOT] = '{default: '{default: 16'd0}};
   logic [15:0] ev_origin [NSRC][NSLOT] = '{default: '{default: 16'd0}};
   logic [7:0]  ev_tag    [NSRC][NSLOT] = '{default: '{default: 8'd0}};
   logic [15:0] src_ticks [NSRC] = '{default: 16'd0};
   int          span_len  [NSRC] = '{default: 1};

   pett_pkg::rsp_type pending_results [$];
   int      fail_count  = 0;
   int      cycle_count = 0;
   int      hold_tokens = 0;
   int      hold_seen   = 0;
   int      stall_left  = 0;
   bit      quiet       = 1'b0;

   // Apply one request to the mirror and queue the responses it must produce
   function automatic void predict_table_results(input pett_pkg::req_type r);
      int                src;
      int                i;
      logic [15:0]       elapsed;
      logic [15:0]       per;
      logic [NSLOT-1:0]  fire_mask;
      pett_pkg::rsp_type o;
      src = int'(r.timer_sel);
      o = '0;
      o.last = 1'b1;
      case (r.func)
         pett_pkg::FUNC_TICK: begin
            fire_mask = '0;
            if (src < NSRC) begin
               src_ticks[src] = src_ticks[src] + 16'd1;
               for (i = 0; i < span_len[src] && i < NSLOT; i++) begin
                  elapsed = src_ticks[src] - ev_origin[src][i];
                  per = (ev_period[src][i] == 16'd0) ? 16'd1 : ev_period[src][i];
                  if (ev_on[src][i] && (elapsed % per) == 16'd0)
                     fire_mask[i] = 1'b1;
               end
            end
            if (fire_mask == '0) begin
               pending_results.push_back(o);
            end else begin
               for (i = 0; i < NSLOT; i++) begin
                  if (fire_mask[i]) begin
                     o.status    = pett_pkg::STATUS_OK;
                     o.slot_out  = FSW'(i);
                     o.fired     = 1'b1;
                     o.fired_tag = ev_tag[src][i];
                     o.last      = ((fire_mask >> (i + 1)) == '0);
                     pending_results.push_back(o);
                  end
               end
            end
         end
         pett_pkg::FUNC_ADD: begin
            o.status = pett_pkg::STATUS_REJECT;
            if (src < NSRC && r.handler_tag != 8'd0) begin
               i = 0;
               while (i < span_len[src] && i < NSLOT && ev_on[src][i])
                  i++;
               if (i < NSLOT) begin
                  if (i >= span_len[src])
                     span_len[src] = i + 1;
                  ev_on[src][i]     = 1'b1;
                  ev_period[src][i] = (r.period == 16'd0) ? 16'd1 : r.period;
                  ev_origin[src][i] = src_ticks[src];
                  ev_tag[src][i]    = r.handler_tag;
                  o.status   = pett_pkg::STATUS_OK;
                  o.slot_out = FSW'(i);
               end
            end
            pending_results.push_back(o);
         end
         pett_pkg::FUNC_REMOVE: begin
            o.slot_out = r.slot;
            if (src >= NSRC || int'(r.slot) >= span_len[src]
                  || int'(r.slot) >= NSLOT) begin
               o.status = pett_pkg::STATUS_REJECT;
            end else begin
               i = int'(r.slot);
               ev_on[src][i]     = 1'b0;
               ev_period[src][i] = 16'd0;
               ev_origin[src][i] = 16'd0;
               ev_tag[src][i]    = 8'd0;
               if (i + 1 == span_len[src])
                  span_len[src] = span_len[src] - 1;
               o.status = pett_pkg::STATUS_OK;
            end
            pending_results.push_back(o);
         end
         default: begin
            o.status = pett_pkg::STATUS_REJECT;
            pending_results.push_back(o);
         end
      endcase
   endfunction

   // Offer one request, hold it until taken, then update the expectations
   task automatic issue_request(input pett_pkg::req_type r, input bit typed,
                                input pett_pkg::rsp_type answer);
      req_bus.valid <= 1'b1;
      req_bus.data  <= r;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      predict_table_results(r);
      if (typed) begin
         void'(pending_results.pop_back());
         pending_results.push_back(answer);
      end
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Response side: compare against the oldest expectation, stall in bursts
   always @(posedge clock) begin
      pett_pkg::rsp_type want;
      pett_pkg::rsp_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = rsp_bus.data;
         if (pending_results.size() == 0) begin
            if (fail_count < REPORT_LIMIT)
               $display("unexpected response: status=%0d slot=%0d fired=%0d tag=%02h last=%0d",
                        got.status, got.slot_out, got.fired, got.fired_tag, got.last);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status || got.slot_out !== want.slot_out
                  || got.fired !== want.fired || got.fired_tag !== want.fired_tag
                  || got.last !== want.last) begin
               if (fail_count < REPORT_LIMIT)
                  $display({"response mismatch: expected status=%0d slot=%0d fired=%0d ",
                            "tag=%02h last=%0d, got status=%0d slot=%0d fired=%0d ",
                            "tag=%02h last=%0d"},
                           want.status, want.slot_out, want.fired, want.fired_tag, want.last,
                           got.status, got.slot_out, got.fired, got.fired_tag, got.last);
               fail_count++;
            end
         end
      end
      if (hold_tokens != hold_seen) begin
         hold_seen  = hold_tokens;
         stall_left = LONG_HOLD;
      end
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      pett_pkg::req_type r;
      int      n;
      int      pick;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.data  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (n = 0; n < DIRECTED_ROWS; n++)
         issue_request(plan[n].req, plan[n].typed, plan[n].rsp);

      // Mostly well-formed traffic on small periods, with some malformed requests mixed in
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         quiet = (n >= 180 && n < 230) || n >= RANDOM_ITEMS - 80;
         if (n == 100)
            hold_tokens++;
         if (n == 280) begin
            req_bus.valid <= 1'b0;
            do @(posedge clock); while (pending_results.size() != 0);
         end
         r.timer_sel   = 1'($urandom_range(0, 1));
         r.slot        = 4'($urandom_range(0, 15));
         r.period      = 16'($urandom_range(0, 7));
         if ($urandom_range(0, 9) == 0)
            r.period = 16'($urandom);
         r.handler_tag = 8'($urandom_range(1, 255));
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            r.func = pett_pkg::FUNC_TICK;
         end else if (pick < 70) begin
            r.func = pett_pkg::FUNC_ADD;
         end else if (pick < 90) begin
            r.func = pett_pkg::FUNC_REMOVE;
            r.slot = 4'($urandom_range(0, NSLOT - 1));
         end else if (pick < 94) begin
            r.func        = pett_pkg::FUNC_ADD;
            r.handler_tag = 8'd0;
         end else if (pick < 98) begin
            r.func = pett_pkg::FUNC_REMOVE;
         end else begin
            r.func = pett_pkg::FUNC_RSVD;
         end
         issue_request(r, PREDICT, '0);
      end

      // Drain
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
